// ===== src/text_mode_console_writer_macros.svh =====
// Assertion macros shared by the console writer RTL.
`ifndef TEXT_MODE_CONSOLE_WRITER_MACROS_SVH
`define TEXT_MODE_CONSOLE_WRITER_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds, outside reset.
`define TMCW_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("console writer assertion failed");

// Check that cons holds in the cycle after ante holds, outside reset.
`define TMCW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("console writer assertion failed");

`endif

// ===== src/tmcw_pkg.sv =====
// Shared types, constants and the CP866 mapping of the console writer.
package tmcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CELL_W      = 16;
    localparam int COLOR_W     = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 32;

    localparam logic [7:0] NEWLINE_CODE  = 8'h0A;
    localparam logic [7:0] BLANK_GLYPH   = 8'h20;
    localparam logic [7:0] UNKNOWN_GLYPH = 8'h3F;

    localparam logic [CFG_INDEX_W-1:0] CFG_FG_COLOR = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BG_COLOR = 1'b1;

    typedef enum logic [2:0] {
        A_WRITE_BYTE,
        A_WRITE_WIDE,
        A_SET_CURSOR,
        A_CLEAR,
        A_READ_CELL
    } t_action;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_SCROLL
    } t_state;

    // Map a code point to CP866; anything without a glyph becomes '?'.
    function automatic logic [7:0] to_cp866(input logic [15:0] wc);
        logic [7:0] g;
        if (wc < 16'h0080) begin
            g = wc[7:0];
        end else if (wc inside {[16'h0410:16'h043F]}) begin
            g = 8'(wc - 16'h0390);  // 0x0410 lands on 0x80
        end else if (wc inside {[16'h0440:16'h044F]}) begin
            g = 8'(wc - 16'h0360);  // 0x0440 lands on 0xE0
        end else if (wc == 16'h0401) begin
            g = 8'hF0;
        end else if (wc == 16'h0451) begin
            g = 8'hF1;
        end else begin
            g = UNKNOWN_GLYPH;
        end
        return g;
    endfunction

endpackage

// ===== src/tmcw_screen_ram.sv =====
// Screen cell store: one write port, one registered read port.
module tmcw_screen_ram
    import tmcw_pkg::*;
#(
    parameter int DEPTH  = DEF_COLUMNS * DEF_ROWS,
    parameter int ADDR_W = $clog2(DEF_COLUMNS * DEF_ROWS)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [CELL_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [CELL_W-1:0] o_rd_data
);

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/text_mode_console_writer.sv =====
// Text-mode console writer top level: sequencer, cursor and screen store.
//
// Input words arrive on s_axis, one action each: write a byte, write a wide
// character (converted to CP866), set the cursor, clear the screen or read
// one cell. Each input word yields one result word on m_axis: the cursor
// after the action, a scroll flag and the cell read back (zero otherwise).
// Colors come from the plain write port and are taken at any time.
//
// Timing: plain writes, newlines without scroll, set cursor and unused
// actions deliver their result in the cycle after acceptance; a read goes
// through S_READ; a clear sweeps all COLUMNS*ROWS cells; a write or newline
// off the last row waits for the copy sweep (one cell per cycle).
// Flow: one word in flight; s_axis_tready is low while the sequencer
// works and while a result waits, so a new word is taken only once the
// result of the last one has been taken.
// If the receiver stalls, the result register holds its word and no input
// is taken.
// Reset: the cursor homes, colors return to gray on black, and a clearing
// pass writes zero into all COLUMNS*ROWS cells, one per cycle, before the
// first input word is taken.
module text_mode_console_writer
    import tmcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // action[2:0], char_code[18:3], col_request[29:19], row_request[40:30]
    input  logic [S_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // cursor_col[6:0], cursor_row[11:7], did_scroll[12], cell_value[28:13]
    output logic [M_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [COLOR_W-1:0]     i_cfg_data
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int KEEP   = CELLS - COLUMNS;     // cells that survive a scroll
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(CELLS - 1);
    localparam logic [CNT_W-1:0] END_SWEEP = CNT_W'(CELLS);

    // Clamp a signed request into 0..COLUMNS-1 / 0..ROWS-1.
    function automatic logic [COL_W-1:0] clamp_col(input logic [10:0] v);
        logic [COL_W-1:0] c;
        if (v[10]) begin
            c = '0;
        end else if (v >= 11'(COLUMNS)) begin
            c = LAST_COL;
        end else begin
            c = COL_W'(v);
        end
        return c;
    endfunction

    function automatic logic [ROW_W-1:0] clamp_row(input logic [10:0] v);
        logic [ROW_W-1:0] r;
        if (v[10]) begin
            r = '0;
        end else if (v >= 11'(ROWS)) begin
            r = LAST_ROW;
        end else begin
            r = ROW_W'(v);
        end
        return r;
    endfunction

    // Sequencer and cursor state.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_line, n_line;
    logic [15:0]        r_scroll_total, n_scroll_total;
    logic [COLOR_W-1:0] r_fg, r_bg;

    // Result register.
    logic              r_out_valid, n_out_valid;
    logic [6:0]        r_out_col, n_out_col;
    logic [4:0]        r_out_row, n_out_row;
    logic              r_out_scroll, n_out_scroll;
    logic [CELL_W-1:0] r_out_cell, n_out_cell;

    // Store ports.
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_wa, ram_ra;
    logic [CELL_W-1:0] ram_wd, ram_rd;

    // Input word fields.
    logic [2:0]  s_action;
    logic [15:0] s_code;
    logic [10:0] s_col_req, s_row_req;

    logic              s_accept;
    logic              is_newline;
    logic [7:0]        glyph;
    logic [7:0]        attr;
    logic [CELL_W-1:0] blank;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] req_addr;
    logic              load;
    logic              load_scroll;
    logic [CELL_W-1:0] load_cell;

    assign s_action  = i_s_axis_tdata[2:0];
    assign s_code    = i_s_axis_tdata[18:3];
    assign s_col_req = i_s_axis_tdata[29:19];
    assign s_row_req = i_s_axis_tdata[40:30];

    assign o_s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign attr  = {r_bg, r_fg};
    assign blank = {attr, BLANK_GLYPH};

    // Byte writes test only the low byte for newline, wide writes the whole code.
    assign is_newline = (s_action == A_WRITE_BYTE) ? (s_code[7:0] == NEWLINE_CODE)
                                                   : (s_code == 16'(NEWLINE_CODE));
    assign glyph = (s_action == A_WRITE_BYTE) ? s_code[7:0] : to_cp866(s_code);

    assign cur_addr = ADDR_W'(r_line * COLUMNS + r_col);
    assign req_addr = ADDR_W'(clamp_row(s_row_req) * COLUMNS + clamp_col(s_col_req));

    tmcw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_ra),
        .o_rd_data (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_INIT;
            r_cnt          <= '0;
            r_col          <= '0;
            r_line         <= '0;
            r_scroll_total <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_cnt          <= n_cnt;
            r_col          <= n_col;
            r_line         <= n_line;
            r_scroll_total <= n_scroll_total;
            r_out_valid    <= n_out_valid;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_out_col    <= n_out_col;
        r_out_row    <= n_out_row;
        r_out_scroll <= n_out_scroll;
        r_out_cell   <= n_out_cell;
    end

    // Color registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= COLOR_W'(7);
            r_bg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FG_COLOR: r_fg <= i_cfg_data;
                CFG_BG_COLOR: r_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_col          = r_col;
        n_line         = r_line;
        n_scroll_total = r_scroll_total;
        n_out_valid    = r_out_valid;
        n_out_col      = r_out_col;
        n_out_row      = r_out_row;
        n_out_scroll   = r_out_scroll;
        n_out_cell     = r_out_cell;
        ram_we         = 1'b0;
        ram_wa         = '0;
        ram_wd         = '0;
        ram_re         = 1'b0;
        ram_ra         = '0;
        load           = 1'b0;
        load_scroll    = 1'b0;
        load_cell      = '0;

        case (r_state)
            S_INIT: begin
                // Zero the store after reset.
                ram_we = 1'b1;
                ram_wa = ADDR_W'(r_cnt);
                ram_wd = '0;
                if (r_cnt == LAST_CELL) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            S_IDLE: begin
                if (s_accept) begin
                    case (s_action)
                        A_WRITE_BYTE, A_WRITE_WIDE: begin
                            if (!is_newline) begin
                                ram_we = 1'b1;
                                ram_wa = cur_addr;
                                ram_wd = {attr, glyph};
                            end
                            if (is_newline || r_col == LAST_COL) begin
                                n_col = '0;
                                if (r_line == LAST_ROW) begin
                                    // Stay on the last row and shift the screen up.
                                    n_state        = S_SCROLL;
                                    n_cnt          = '0;
                                    n_scroll_total = r_scroll_total + 16'd1;
                                end else begin
                                    n_line = r_line + 1'b1;
                                    load   = 1'b1;
                                end
                            end else begin
                                n_col = r_col + 1'b1;
                                load  = 1'b1;
                            end
                        end
                        A_SET_CURSOR: begin
                            n_col  = clamp_col(s_col_req);
                            n_line = clamp_row(s_row_req);
                            load   = 1'b1;
                        end
                        A_CLEAR: begin
                            n_col   = '0;
                            n_line  = '0;
                            n_cnt   = '0;
                            n_state = S_CLEAR;
                        end
                        A_READ_CELL: begin
                            ram_re  = 1'b1;
                            ram_ra  = req_addr;
                            n_state = S_READ;
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end

            S_READ: begin
                load      = 1'b1;
                load_cell = ram_rd;
                n_state   = S_IDLE;
            end

            S_CLEAR: begin
                ram_we = 1'b1;
                ram_wa = ADDR_W'(r_cnt);
                ram_wd = blank;
                if (r_cnt == LAST_CELL) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                    load    = 1'b1;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            S_SCROLL: begin
                // Read one line ahead, write the cell fetched last cycle;
                // the bottom line gets blanks.
                if (r_cnt < CNT_W'(KEEP)) begin
                    ram_re = 1'b1;
                    ram_ra = ADDR_W'(r_cnt + COLUMNS);
                end
                if (r_cnt != '0) begin
                    ram_we = 1'b1;
                    ram_wa = ADDR_W'(r_cnt - 1'b1);
                    ram_wd = (r_cnt <= CNT_W'(KEEP)) ? ram_rd : blank;
                end
                if (r_cnt == END_SWEEP) begin
                    n_cnt       = '0;
                    n_state     = S_IDLE;
                    load        = 1'b1;
                    load_scroll = 1'b1;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Load the result register, or drop the word once taken.
        if (load) begin
            n_out_valid  = 1'b1;
            n_out_col    = 7'(n_col);
            n_out_row    = 5'(n_line);
            n_out_scroll = load_scroll;
            n_out_cell   = load_cell;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_cell, r_out_scroll, r_out_row, r_out_col};

`include "text_mode_console_writer_macros.svh"

    `TMCW_ASSERT_NOW(a_cursor_range, i_clk, i_rst_n, 1'b1,
        (r_col <= LAST_COL) && (r_line <= LAST_ROW))
    `TMCW_ASSERT_NOW(a_scroll_cursor, i_clk, i_rst_n, r_out_valid && r_out_scroll,
        (r_out_col == 7'd0) && (r_out_row == 5'(LAST_ROW)))
    `TMCW_ASSERT_NOW(a_write_source, i_clk, i_rst_n, ram_we,
        (r_state != S_IDLE) || s_accept)
    `TMCW_ASSERT_NEXT(a_scroll_done, i_clk, i_rst_n,
        (r_state == S_SCROLL) && (r_cnt == END_SWEEP), r_out_valid && r_out_scroll)

endmodule
